// File: src/mtx3_pkg.sv
// ----------------------------------------------------------------------------
// mtx3_pkg
// Shared widths and the cofactor operand map for the 3x3 inverse pipeline.
// ----------------------------------------------------------------------------
package mtx3_pkg;

	localparam int ELEM_W    = 32;                 // element width, Q16.16
	localparam int FRAC_BITS = 16;
	localparam int N_ELEM    = 9;
	localparam int SHIFT     = 2 * FRAC_BITS;      // dividend pre-shift
	localparam int PROD_W    = 2 * ELEM_W;         // element product
	localparam int COF_W     = 2 * ELEM_W + 1;     // signed cofactor
	localparam int CMAG_W    = 2 * ELEM_W;         // cofactor magnitude
	localparam int PART_W    = 2 * ELEM_W + 1;     // element x cofactor half
	localparam int DET_W     = 3 * ELEM_W + 1;     // signed determinant
	localparam int DMAG_W    = 3 * ELEM_W;         // determinant magnitude
	localparam int NUM_W     = CMAG_W + SHIFT;     // shifted dividend
	localparam int Q_W       = ELEM_W + 1;         // quotient bits kept
	localparam int DIV_LAT   = Q_W + 2;            // divider lane stages

	// Operands a, b, c, d of cofactor k = a*b - c*d, by row-major index
	localparam int unsigned COF_IDX [0:N_ELEM-1][0:3] = '{
		'{4, 8, 7, 5},
		'{7, 2, 1, 8},
		'{1, 5, 4, 2},
		'{6, 5, 3, 8},
		'{0, 8, 6, 2},
		'{3, 2, 0, 5},
		'{3, 7, 6, 4},
		'{6, 1, 0, 7},
		'{0, 4, 3, 1}
	};

endpackage

// File: src/matrix3_inverse_core.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_core
// Inverse of a signed Q16.16 3x3 matrix through adjugate over determinant.
// ----------------------------------------------------------------------------
// Pipeline: the 33-stage quotient pipeline in each divider lane plus eight
// arithmetic stages lie between input transfer and result.
// Throughput: one matrix per cycle; the whole pipeline halts while a
// result waits at the output.
// Reset: arst_n clears the valid flags only; no result is pending after it.
module matrix3_inverse_core import mtx3_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [N_ELEM*ELEM_W-1:0]     s_tdata,   // m00, m01, m02, m10 .. m22
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [N_ELEM*ELEM_W-1:0]     m_tdata,   // inv00, inv01, inv02 .. inv22
	output logic [1:0]                   m_tuser    // singular, saturated
);

	localparam int PIPE_L = 6 + DIV_LAT;

	logic              ce;
	logic [PIPE_L-1:0] vld_q;

	// Advance whenever the output slot is free or being taken
	assign ce       = !vld_q[PIPE_L-1] || m_tready;
	assign s_tready = ce;
	assign m_tvalid = vld_q[PIPE_L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ce) begin
			vld_q <= {vld_q[PIPE_L-2:0], s_tvalid};
		end
	end

	logic signed [ELEM_W-1:0] elem [0:N_ELEM-1];
	for (genvar k = 0; k < N_ELEM; k++) begin : g_unpack
		assign elem[k] = s_tdata[k*ELEM_W +: ELEM_W];
	end

	// Nine cofactor lanes
	logic signed [COF_W-1:0] cof_s2 [0:N_ELEM-1];
	for (genvar k = 0; k < N_ELEM; k++) begin : g_cof
		mtx3_cof_lane u_cof (
			.clk    (clk),
			.ce     (ce),
			.a      (elem[COF_IDX[k][0]]),
			.b      (elem[COF_IDX[k][1]]),
			.c      (elem[COF_IDX[k][2]]),
			.d      (elem[COF_IDX[k][3]]),
			.cof_s2 (cof_s2[k])
		);
	end

	// Hold first-row elements and cofactors until the divider lanes
	logic signed [ELEM_W-1:0] row_s1 [0:2];
	logic signed [ELEM_W-1:0] row_s2 [0:2];
	logic signed [COF_W-1:0]  cof_s3 [0:N_ELEM-1];
	logic signed [COF_W-1:0]  cof_s4 [0:N_ELEM-1];
	logic signed [COF_W-1:0]  cof_s5 [0:N_ELEM-1];
	logic signed [COF_W-1:0]  cof_s6 [0:N_ELEM-1];

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int j = 0; j < 3; j++) begin
				row_s1[j] <= elem[j];
				row_s2[j] <= row_s1[j];
			end
			for (int k = 0; k < N_ELEM; k++) begin
				cof_s3[k] <= cof_s2[k];
				cof_s4[k] <= cof_s3[k];
				cof_s5[k] <= cof_s4[k];
				cof_s6[k] <= cof_s5[k];
			end
		end
	end

	// Determinant: split cofactors 0, 3 and 6 into halves for the products
	logic signed [PART_W-1:0] plo_s3 [0:2];
	logic signed [PART_W-1:0] phi_s3 [0:2];
	logic [DET_W-1:0]         term_s4 [0:2];

	for (genvar j = 0; j < 3; j++) begin : g_det
		logic signed [ELEM_W:0] lo_ext;
		logic signed [ELEM_W:0] hi_part;
		assign lo_ext  = {1'b0, cof_s2[3*j][ELEM_W-1:0]};
		assign hi_part = cof_s2[3*j][COF_W-1:ELEM_W];

		always_ff @(posedge clk) begin
			if (ce) begin
				plo_s3[j]  <= row_s2[j] * lo_ext;
				phi_s3[j]  <= row_s2[j] * hi_part;
				term_s4[j] <= {phi_s3[j], {ELEM_W{1'b0}}}
				            + {{ELEM_W{plo_s3[j][PART_W-1]}}, plo_s3[j]};
			end
		end
	end

	logic [DET_W-1:0]  det_s5;
	logic [DET_W-1:0]  det_neg;
	logic [DMAG_W-1:0] dmag_s6;
	logic              dneg_s6;
	logic              sing_s [0:DIV_LAT];

	assign det_neg = -det_s5;

	// Sum the terms, then take sign and magnitude
	always_ff @(posedge clk) begin
		if (ce) begin
			det_s5    <= term_s4[0] + term_s4[1] + term_s4[2];
			dneg_s6   <= det_s5[DET_W-1];
			dmag_s6   <= det_s5[DET_W-1] ? det_neg[DMAG_W-1:0] : det_s5[DMAG_W-1:0];
			sing_s[0] <= (det_s5 == '0);
			for (int i = 0; i < DIV_LAT; i++) begin
				sing_s[i+1] <= sing_s[i];
			end
		end
	end

	// Nine divider lanes
	logic [ELEM_W-1:0] value_s [0:N_ELEM-1];
	logic [N_ELEM-1:0] sat_s;
	for (genvar k = 0; k < N_ELEM; k++) begin : g_div
		mtx3_div_lane u_div (
			.clk     (clk),
			.ce      (ce),
			.cof     (cof_s6[k]),
			.dmag    (dmag_s6),
			.dneg    (dneg_s6),
			.value_s (value_s[k]),
			.sat_s   (sat_s[k])
		);
		assign m_tdata[k*ELEM_W +: ELEM_W] = sing_s[DIV_LAT] ? '0 : value_s[k];
	end

	// Merge lane flags
	assign m_tuser[0] = sing_s[DIV_LAT];
	assign m_tuser[1] = !sing_s[DIV_LAT] && (|sat_s);

	a_sing_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tuser[1])
		else $error("singular result flagged as saturated");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("singular result carries non-zero elements");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

endmodule

// File: src/mtx3_cof_lane.sv
// ----------------------------------------------------------------------------
// mtx3_cof_lane
// One 2x2 cofactor a*b - c*d: products in the first stage, difference in the second.
// ----------------------------------------------------------------------------
module mtx3_cof_lane import mtx3_pkg::*; (
	input  logic                     clk,
	input  logic                     ce,
	input  logic signed [ELEM_W-1:0] a,
	input  logic signed [ELEM_W-1:0] b,
	input  logic signed [ELEM_W-1:0] c,
	input  logic signed [ELEM_W-1:0] d,
	output logic signed [COF_W-1:0]  cof_s2
);

	logic signed [PROD_W-1:0] pab_s1;
	logic signed [PROD_W-1:0] pcd_s1;

	// Form both products
	always_ff @(posedge clk) begin
		if (ce) begin
			pab_s1 <= a * b;
			pcd_s1 <= c * d;
		end
	end

	// Subtract with one guard bit
	always_ff @(posedge clk) begin
		if (ce) begin
			cof_s2 <= {pab_s1[PROD_W-1], pab_s1} - {pcd_s1[PROD_W-1], pcd_s1};
		end
	end

endmodule

// File: src/mtx3_div_lane.sv
// ----------------------------------------------------------------------------
// mtx3_div_lane
// Pipelined restoring divider: cofactor * 2^SHIFT / determinant, one quotient
// bit per stage, truncated toward zero and clipped to the element range.
// ----------------------------------------------------------------------------
module mtx3_div_lane import mtx3_pkg::*; (
	input  logic                     clk,
	input  logic                     ce,
	input  logic signed [COF_W-1:0]  cof,
	input  logic [DMAG_W-1:0]        dmag,
	input  logic                     dneg,
	output logic [ELEM_W-1:0]        value_s,
	output logic                     sat_s
);

	logic [COF_W-1:0]  cof_neg;
	logic [CMAG_W-1:0] cmag;
	logic [NUM_W-1:0]  num;
	logic [DMAG_W-1:0] rem_init;

	logic [DMAG_W-1:0] rem_s  [0:Q_W];
	logic [Q_W-1:0]    low_s  [0:Q_W];
	logic [Q_W-1:0]    quo_s  [0:Q_W];
	logic [DMAG_W-1:0] dmag_s [0:Q_W];
	logic              big_s  [0:Q_W];
	logic              neg_s  [0:Q_W];

	// Take the cofactor magnitude and the first partial remainder
	always_comb begin
		cof_neg  = -cof;
		cmag     = cof[COF_W-1] ? cof_neg[CMAG_W-1:0] : cof[CMAG_W-1:0];
		num      = {cmag, {SHIFT{1'b0}}};
		rem_init = DMAG_W'(num >> Q_W);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			rem_s[0]  <= rem_init;
			low_s[0]  <= num[Q_W-1:0];
			quo_s[0]  <= '0;
			dmag_s[0] <= dmag;
			big_s[0]  <= (rem_init >= dmag);
			neg_s[0]  <= cof[COF_W-1] ^ dneg;
		end
	end

	// One quotient bit per stage, most significant first
	for (genvar i = 0; i < Q_W; i++) begin : g_step
		logic [DMAG_W:0] trial;
		logic [DMAG_W:0] diff;
		logic            fits;

		always_comb begin
			trial = {rem_s[i], low_s[i][Q_W-1]};
			diff  = trial - {1'b0, dmag_s[i]};
			fits  = (trial >= {1'b0, dmag_s[i]});
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[i+1]  <= fits ? diff[DMAG_W-1:0] : trial[DMAG_W-1:0];
				low_s[i+1]  <= {low_s[i][Q_W-2:0], 1'b0};
				quo_s[i+1]  <= {quo_s[i][Q_W-2:0], fits};
				dmag_s[i+1] <= dmag_s[i];
				big_s[i+1]  <= big_s[i];
				neg_s[i+1]  <= neg_s[i];
			end
		end
	end

	logic [Q_W-1:0] lim;
	logic           over;
	logic [Q_W-1:0] mag;
	logic [Q_W-1:0] signed_q;

	// Clip to the signed range and apply the sign
	always_comb begin
		lim      = neg_s[Q_W] ? {2'b01, {(ELEM_W-1){1'b0}}} : {2'b00, {(ELEM_W-1){1'b1}}};
		over     = big_s[Q_W] || (quo_s[Q_W] > lim);
		mag      = over ? lim : quo_s[Q_W];
		signed_q = neg_s[Q_W] ? -mag : mag;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			value_s <= signed_q[ELEM_W-1:0];
			sat_s   <= over;
		end
	end

endmodule
